[rtl/core/snp_pkg.sv]
// ----------------------------------------------------------------------------
// snp_pkg - shared types for the sparse neuron potential block
// Command and result words, the token that moves down the cell chain,
// and the saturation helpers used by each cell.
// ----------------------------------------------------------------------------
package snp_pkg;

	localparam int ADDR_W   = 12;
	localparam int WEIGHT_W = 16;
	localparam int OFFSET_W = 8;
	localparam int CNT_W    = 5;
	localparam int SUM_W    = 48;
	localparam int POT_W    = 32;
	localparam int NEURON_W = 4;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_PAIR   = 2'd1,
		OP_FINISH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [ADDR_W-1:0]          weight_address;
		logic signed [WEIGHT_W-1:0] weight_value;
		logic [OFFSET_W-1:0]        offset;
		logic signed [WEIGHT_W-1:0] sample_value;
	} cmd_word_t;

	typedef struct packed {
		logic [NEURON_W-1:0]     neuron;
		logic signed [POT_W-1:0] potential;
		logic                    range_error;
		logic                    last;
	} result_word_t;

	// token moving down the cell chain, one hop per cycle
	typedef struct packed {
		logic                       valid;
		op_t                        op;
		logic [ADDR_W-1:0]          addr;   // write: store address, pair: position
		logic signed [WEIGHT_W-1:0] data;   // write: weight, pair: sample
		logic                       err;    // finish: range error of the list
		logic [CNT_W-1:0]           count;  // finish: neurons to emit
	} token_t;

	typedef struct packed {
		logic         valid;
		result_word_t word;
	} cell_res_t;

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
		logic signed [SUM_W-1:0] r;
		if (v[SUM_W] != v[SUM_W-1]) begin
			r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			r = v[SUM_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [POT_W-1:0] sat_pot(input logic signed [SUM_W:0] v);
		logic signed [SUM_W:0] hi;
		logic signed [SUM_W:0] lo;
		logic signed [POT_W-1:0] r;
		hi = {{(SUM_W-POT_W+2){1'b0}}, {(POT_W-1){1'b1}}};
		lo = -hi - 1;
		if (v > hi) begin
			r = {1'b0, {(POT_W-1){1'b1}}};
		end else if (v < lo) begin
			r = {1'b1, {(POT_W-1){1'b0}}};
		end else begin
			r = v[POT_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/snp_cell.sv]
// ----------------------------------------------------------------------------
// snp_cell - one neuron of the chain
// Holds the neuron's weights and partial sum, acts on each token and hands
// the token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module snp_cell
	import snp_pkg::*;
#(
	parameter int IDX                = 0,
	parameter int WEIGHTS_PER_NEURON = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  token_t    tin,
	output token_t    tout,
	output cell_res_t res
);

	localparam int POS_W = (WEIGHTS_PER_NEURON > 1) ? $clog2(WEIGHTS_PER_NEURON) : 1;
	localparam int BASE  = IDX * WEIGHTS_PER_NEURON;

	logic signed [WEIGHT_W-1:0] wmem_q [WEIGHTS_PER_NEURON];

	logic                       wr_hit;
	logic [POS_W-1:0]           wr_idx;
	logic [POS_W-1:0]           rd_idx;
	logic signed [WEIGHT_W-1:0] rd_s1;
	token_t                     tok_s1;
	token_t                     tok_s2;
	logic signed [WEIGHT_W-1:0] w_s2;
	logic signed [POT_W-1:0]    prod_s2;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W:0]      acc_sum;
	logic signed [SUM_W:0]      pot_diff;
	logic signed [WEIGHT_W-1:0] smp_s1;
	logic                       emit;
	cell_res_t                  res_q;

	assign wr_hit = tin.valid && (tin.op == OP_WRITE) && (32'(tin.addr) >= BASE)
		&& (32'(tin.addr) < BASE + WEIGHTS_PER_NEURON);
	assign wr_idx = POS_W'(32'(tin.addr) - BASE);
	// finish reads the bias at position 0
	assign rd_idx = (tin.op == OP_PAIR) ? tin.addr[POS_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			wmem_q[wr_idx] <= tin.data;
		end
		rd_s1 <= wmem_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			tok_s1 <= tin;
			tok_s2 <= tok_s1;
		end
	end

	assign tout   = tok_s1;
	assign smp_s1 = tok_s1.data;

	always_ff @(posedge clk) begin
		w_s2    <= rd_s1;
		prod_s2 <= POT_W'(rd_s1) * POT_W'(smp_s1);
	end

	assign acc_sum  = (SUM_W+1)'(sum_q) + (SUM_W+1)'(prod_s2);
	assign pot_diff = (SUM_W+1)'(sum_q) - (SUM_W+1)'(w_s2);
	assign emit     = 32'(IDX) < 32'(tok_s2.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			res_q <= '0;
		end else begin
			res_q.valid <= 1'b0;
			if (tok_s2.valid && tok_s2.op == OP_PAIR) begin
				sum_q <= sat_sum(acc_sum);
			end else if (tok_s2.valid && tok_s2.op == OP_FINISH) begin
				sum_q       <= '0;
				res_q.valid <= emit;
			end
			res_q.word.neuron      <= NEURON_W'(IDX);
			res_q.word.potential   <= sat_pot(pot_diff);
			res_q.word.range_error <= tok_s2.err;
			res_q.word.last        <= (32'(IDX) + 1) == 32'(tok_s2.count);
		end
	end

	assign res = res_q;

endmodule

[rtl/core/sparse_neuron_potential.sv]
// ----------------------------------------------------------------------------
// sparse_neuron_potential - sparse indexed dot product over a neuron chain
// Weight writes, offset/value pairs and finish commands stream through a row
// of neuron cells; finish emits one potential per active neuron.
// ----------------------------------------------------------------------------
//
//  channel   | ports                              | handshake
//  ----------+------------------------------------+------------------------------
//  command   | start, busy, cmd                   | word taken when start && !busy
//  result    | result_strobe, result              | one-cycle strobe per word, no stall
//  config    | cfg_we, cfg_wdata (active_outputs) | written when cfg_we is high
//
// Writes and pairs are taken one per cycle while busy is low. A finish is
// registered in tok_s0, then passes each cell's tok_s1; cell n's tok_s2,
// result register and the output register give neuron n's word. The
// finish reaches cell n after cells 0 to n-1, so the words leave one per
// cycle; busy is held after a finish so two lists never share a result slot.
// Reset clears the sums, position, error flag and active_outputs (to 16);
// weight memories are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sparse_neuron_potential
	import snp_pkg::*;
#(
	parameter int WEIGHTS_PER_NEURON = 256,
	parameter int MAX_OUTPUTS        = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_word_t        cmd,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic             result_strobe,
	output result_word_t     result
);

	localparam int POS_W  = (WEIGHTS_PER_NEURON > 1) ? $clog2(WEIGHTS_PER_NEURON) : 1;
	localparam int NEXT_W = ((POS_W > OFFSET_W) ? POS_W : OFFSET_W) + 1;
	localparam int RES_W  = $bits(result_word_t);

	logic [CNT_W-1:0]   active_q;   // active_outputs register
	logic [POS_W-1:0]   pos_q;      // running weight position
	logic               err_q;      // a pair of this list ran past the end
	logic [CNT_W-1:0]   hold_q;     // cycles left before another command is taken
	token_t             tok_s0;     // token entering cell 0
	logic               accept;
	logic [NEXT_W-1:0]  next_pos;
	logic               past_end;
	logic [CNT_W-1:0]   count;
	logic               res_any;
	logic [RES_W-1:0]   res_or;
	logic               strobe_q;
	result_word_t       result_q;

	token_t                     tok [MAX_OUTPUTS];
	cell_res_t                  cres [MAX_OUTPUTS];
	logic [MAX_OUTPUTS-1:0]     cres_valid;

	assign accept   = start && !busy;
	assign busy     = hold_q != '0;
	assign next_pos = NEXT_W'(pos_q) + NEXT_W'(cmd.offset);
	assign past_end = 32'(next_pos) >= WEIGHTS_PER_NEURON;

	// zero behaves as one, large values clamp to the number of cells
	always_comb begin
		if (active_q == '0) begin
			count = CNT_W'(1);
		end else if (32'(active_q) > MAX_OUTPUTS) begin
			count = CNT_W'(MAX_OUTPUTS);
		end else begin
			count = active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CNT_W'(16);
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// command decode: position and error tracking, token launch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			err_q  <= 1'b0;
			hold_q <= '0;
			tok_s0 <= '0;
		end else begin
			tok_s0.valid <= 1'b0;
			if (hold_q != '0) begin
				hold_q <= hold_q - CNT_W'(1);
			end
			if (accept) begin
				tok_s0.op    <= cmd.op;
				tok_s0.err   <= err_q;
				tok_s0.count <= count;
				case (cmd.op)
					OP_WRITE: begin
						tok_s0.valid <= 1'b1;
						tok_s0.addr  <= cmd.weight_address;
						tok_s0.data  <= cmd.weight_value;
					end
					OP_PAIR: begin
						tok_s0.addr <= ADDR_W'(next_pos);
						tok_s0.data <= cmd.sample_value;
						if (past_end) begin
							err_q <= 1'b1;
						end else begin
							tok_s0.valid <= 1'b1;
							pos_q        <= POS_W'(next_pos);
						end
					end
					OP_FINISH: begin
						tok_s0.valid <= 1'b1;
						pos_q        <= '0;
						err_q        <= 1'b0;
						hold_q       <= count - CNT_W'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign tok[0] = tok_s0;

	for (genvar g = 0; g < MAX_OUTPUTS; g++) begin : g_cell
		if (g < MAX_OUTPUTS - 1) begin : g_mid
			snp_cell #(
				.IDX                (g),
				.WEIGHTS_PER_NEURON (WEIGHTS_PER_NEURON)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tin    (tok[g]),
				.tout   (tok[g+1]),
				.res    (cres[g])
			);
		end else begin : g_end
			snp_cell #(
				.IDX                (g),
				.WEIGHTS_PER_NEURON (WEIGHTS_PER_NEURON)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tin    (tok[g]),
				.tout   (),
				.res    (cres[g])
			);
		end
		assign cres_valid[g] = cres[g].valid;
	end

	// finish is staggered along the chain, so at most one cell reports
	always_comb begin
		res_or = '0;
		for (int i = 0; i < MAX_OUTPUTS; i++) begin
			res_or = res_or | (cres[i].word & {RES_W{cres[i].valid}});
		end
	end

	assign res_any = |cres_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res_any;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_or;
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	a_one_cell: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cres_valid))
		else $error("two cells reported in one cycle");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == OP_FINISH |=> pos_q == '0 && !err_q)
		else $error("finish did not clear position and error");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < WEIGHTS_PER_NEURON)
		else $error("position past end of neuron");

	a_list_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |=> result_strobe)
		else $error("gap inside a result list");

endmodule

[bench/sparse_neuron_potential_tb.sv]
// ----------------------------------------------------------------------------
// sparse_neuron_potential_tb - self-checking bench for the neuron potential block
// Loads weight columns, streams offset/value lists and finish commands with
// random sender gaps, and checks every potential word against a cycle-free
// model of the sums kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module sparse_neuron_potential_tb;
	import snp_pkg::*;

	localparam int STRIDE       = 256;              // weights per neuron
	localparam int NEURONS      = 16;               // neuron cells in the chain
	localparam int DRAIN_CYCLES = 4 + NEURONS + 4;  // chain depth plus result pipe
	localparam int QUIET_LIMIT  = 2000;             // cycles with no word moving

	localparam logic signed [WEIGHT_W-1:0] W_MIN = 16'sh8000;
	localparam logic signed [WEIGHT_W-1:0] W_MAX = 16'sh7FFF;

	// ------------------------------------------------------------------------
	// Scoreboard: mirror of the weight store, sums, position and error flag.
	// Each accepted command updates the mirror; a finish queues the words due.
	// ------------------------------------------------------------------------
	class potential_scoreboard;
		localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
		localparam longint SUM_LO = -SUM_HI - 1;
		localparam longint POT_HI = 64'sh0000_0000_7FFF_FFFF;
		localparam longint POT_LO = -POT_HI - 1;

		logic signed [WEIGHT_W-1:0] weights [STRIDE*NEURONS];
		bit                         written [STRIDE*NEURONS];
		longint                     sums    [NEURONS];
		int unsigned                pos;
		bit                         overran;
		logic [CNT_W-1:0]           active;
		result_word_t               due_words[$];
		int unsigned                failures;
		int unsigned                words_taken;
		int unsigned                words_checked;
		int unsigned                lists_closed;

		function new();
			foreach (sums[n]) sums[n] = 0;
			foreach (written[a]) written[a] = 1'b0;
			pos     = 0;
			overran = 1'b0;
			active  = CNT_W'(NEURONS);
		endfunction

		// a position can be read only once every neuron has a weight there
		function bit column_ready(int unsigned p);
			for (int n = 0; n < NEURONS; n++)
				if (!written[n*STRIDE + p]) return 1'b0;
			return 1'b1;
		endfunction

		function void set_active(logic [CNT_W-1:0] v);
			active = v;
		endfunction

		function void take_command(cmd_word_t w);
			int unsigned  next;
			int unsigned  count;
			longint       acc;
			longint       pot;
			result_word_t r;
			words_taken++;
			case (w.op)
				OP_WRITE: begin
					// 12-bit address always lands inside the 4096-entry store
					weights[w.weight_address] = w.weight_value;
					written[w.weight_address] = 1'b1;
				end
				OP_PAIR: begin
					next = pos + w.offset;
					if (next >= STRIDE) begin
						overran = 1'b1;  // pair dropped, sums and position kept
					end else begin
						pos = next;
						for (int n = 0; n < NEURONS; n++) begin
							acc = sums[n] + longint'(weights[n*STRIDE + pos]) *
								longint'($signed(w.sample_value));
							if (acc > SUM_HI) acc = SUM_HI;
							if (acc < SUM_LO) acc = SUM_LO;
							sums[n] = acc;
						end
					end
				end
				OP_FINISH: begin
					count = active;
					if (count < 1) count = 1;
					if (count > NEURONS) count = NEURONS;
					for (int n = 0; n < count; n++) begin
						pot = sums[n] - longint'(weights[n*STRIDE]);
						if (pot > POT_HI) pot = POT_HI;
						if (pot < POT_LO) pot = POT_LO;
						r.neuron      = NEURON_W'(n);
						r.potential   = pot[POT_W-1:0];
						r.range_error = overran;
						r.last        = (n + 1 == count);
						due_words = {due_words, r};
					end
					foreach (sums[n]) sums[n] = 0;
					pos     = 0;
					overran = 1'b0;
					lists_closed++;
				end
				default: ;  // unused code, no effect
			endcase
		endfunction

		function void check_word(result_word_t got);
			result_word_t want;
			if (due_words.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected word: neuron %0d potential %0d err %0b last %0b",
						got.neuron, got.potential, got.range_error, got.last);
				return;
			end
			want = due_words.pop_front();
			words_checked++;
			if (got.neuron !== want.neuron || got.potential !== want.potential ||
					got.range_error !== want.range_error || got.last !== want.last) begin
				failures++;
				if (failures <= 10) begin
					$display("mismatch: want neuron %0d potential %0d err %0b last %0b",
						want.neuron, want.potential, want.range_error, want.last);
					$display("           got neuron %0d potential %0d err %0b last %0b",
						got.neuron, got.potential, got.range_error, got.last);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup; every input starts at a known value
	// ------------------------------------------------------------------------
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	cmd_word_t        cmd       = '0;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             result_strobe;
	result_word_t     result;

	potential_scoreboard sb;
	bit                  steady   = 1'b0;  // no sender gaps while set
	int unsigned         settings = 0;
	int unsigned         quiet    = 0;

	sparse_neuron_potential #(
		.WEIGHTS_PER_NEURON(STRIDE),
		.MAX_OUTPUTS       (NEURONS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_strobe(result_strobe),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result words cannot be held off: check each one on the edge that ends it
	always @(posedge clk) begin
		if (arst_n && result_strobe) sb.check_word(result);
	end

	// watchdog: any command or result word moving resets the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("sparse_neuron_potential_tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// weight or sample value, leaning on the extremes now and then
	function automatic logic signed [WEIGHT_W-1:0] pick_weight();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8) return W_MIN;
		if (roll < 16) return W_MAX;
		if (roll < 20) return '0;
		return WEIGHT_W'($urandom);
	endfunction

	// unused fields carry random bits so every input bit toggles
	function automatic cmd_word_t noise_word(op_t op);
		cmd_word_t w;
		w.op             = op;
		w.weight_address = ADDR_W'($urandom);
		w.weight_value   = WEIGHT_W'($urandom);
		w.offset         = OFFSET_W'($urandom);
		w.sample_value   = WEIGHT_W'($urandom);
		return w;
	endfunction

	// Offset for the next pair. Normal pairs land on a column that is written
	// in every neuron (offset 0 included); an overrun pair runs past the end.
	function automatic logic [OFFSET_W-1:0] pick_offset(bit overrun);
		int unsigned spots[$];
		if (overrun && sb.pos > 0)
			return OFFSET_W'($urandom_range(255, STRIDE - sb.pos));
		for (int unsigned p = sb.pos; p < STRIDE; p++)
			if (sb.column_ready(p)) spots = {spots, p - sb.pos};
		return OFFSET_W'(spots[$urandom_range(spots.size() - 1)]);
	endfunction

	// one command word; start stays high after acceptance until the caller
	// drives the next word or lowers it in that same step
	task automatic send_word(cmd_word_t w);
		while (!steady && $urandom_range(99) < 30) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= w;
		do @(posedge clk); while (busy);
		sb.take_command(w);
	endtask

	task automatic write_weight(int unsigned n, int unsigned p,
			logic signed [WEIGHT_W-1:0] v);
		cmd_word_t w;
		w = noise_word(OP_WRITE);
		w.weight_address = ADDR_W'(n*STRIDE + p);
		w.weight_value   = v;
		send_word(w);
	endtask

	// fill one position across all neurons so pairs may land there
	task automatic write_column(int unsigned p);
		for (int n = 0; n < NEURONS; n++) write_weight(n, p, pick_weight());
	endtask

	task automatic send_pair(logic [OFFSET_W-1:0] off, logic signed [WEIGHT_W-1:0] sample);
		cmd_word_t w;
		w = noise_word(OP_PAIR);
		w.offset       = off;
		w.sample_value = sample;
		send_word(w);
	endtask

	task automatic send_finish();
		send_word(noise_word(OP_FINISH));
	endtask

	// drop start, let every due word come out, then let the chain empty
	task automatic settle();
		start <= 1'b0;
		while (sb.due_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_active(logic [CNT_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_active(v);
		settings++;
	endtask

	// Random lists: sometimes a fresh column or a stray write first, then a
	// handful of pairs (a few overrunning, a few unused codes mixed in), and
	// mostly a finish. Lists left open carry on into the next round.
	task automatic random_lists(int unsigned budget);
		int unsigned sent;
		int unsigned pairs;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(9))
				0: begin
					write_column($urandom_range(STRIDE - 2, 1));
					sent += NEURONS;
				end
				1: begin
					send_word(noise_word(OP_WRITE));
					sent++;
				end
				default: ;
			endcase
			pairs = $urandom_range(7, 1);
			repeat (pairs) begin
				if ($urandom_range(19) == 0) send_word(noise_word(OP_NONE));
				send_pair(pick_offset($urandom_range(9) == 0), pick_weight());
				sent++;
			end
			if ($urandom_range(9) != 0) begin
				send_finish();
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	logic [CNT_W-1:0] phase_active [6] = '{5'd5, 5'd17, 5'd1, 5'd16, 5'd0, 5'd12};

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// biases plus positions 1 and 255 in every neuron; neurons 0 and 1 get
		// the extreme weights used by the saturation checks
		write_column(0);
		write_column(1);
		write_column(STRIDE - 1);
		write_weight(0, 0, W_MIN);
		write_weight(1, 0, W_MAX);
		write_weight(0, STRIDE - 1, W_MIN);
		write_weight(1, STRIDE - 1, W_MAX);

		// empty list: potential is the negated bias alone
		send_finish();
		// offset 0 reads the bias position, then walk to the last position and
		// run one pair past the end
		send_pair(8'd0, W_MAX);
		send_pair(8'd1, W_MIN);
		send_pair(8'd254, W_MIN);
		send_pair(8'd1, 16'sh0001);
		send_finish();
		// largest offset, once past the end and once from position 0
		send_pair(8'd1, 16'sh1234);
		send_pair(8'd255, 16'sh4321);
		send_finish();
		send_pair(8'd255, 16'sh0F0F);
		// unused op code, then a finish with the error flag cleared
		send_word(noise_word(OP_NONE));
		send_finish();
		// three max products push neurons 0 and 1 past the 32-bit limits
		send_pair(8'd255, W_MIN);
		send_pair(8'd0, W_MIN);
		send_pair(8'd0, W_MIN);
		send_finish();

		// one neuron, zero taken as one, oversize taken as all
		set_active(5'd1);
		send_finish();
		set_active(5'd0);
		send_pair(8'd1, W_MAX);
		send_finish();
		set_active(5'd31);
		send_finish();

		// random lists under several neuron counts, one phase with no gaps
		for (int k = 0; k < 6; k++) begin
			set_active(k == 4 ? CNT_W'($urandom) : phase_active[k]);
			steady = (k == 3);
			random_lists(65);
		end
		steady = 1'b0;

		settle();
		$display("sparse_neuron_potential_tb: %0d command words, %0d result words, %0d lists",
			sb.words_taken, sb.words_checked, sb.lists_closed);
		$display("  %0d neuron-count settings, potentials driven past both 32-bit limits",
			settings);
		if (sb.due_words.size() != 0)
			$display("%0d expected words never came out", sb.due_words.size());
		if (sb.failures == 0 && sb.due_words.size() == 0) begin
			$display("sparse_neuron_potential_tb: done, clean");
		end else begin
			$display("sparse_neuron_potential_tb: done, errors");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/snp_pkg.sv
rtl/core/snp_cell.sv
rtl/core/sparse_neuron_potential.sv
bench/sparse_neuron_potential_tb.sv
